### src/fpmlp_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point perceptron package
// Shared types, constants and the activation function used by the
// forward-pass datapath.
// ----------------------------------------------------------------------------
package fpmlp_pkg;

  // Default network shape and weight store depth.
  localparam int NUM_INPUTS_DEF        = 4;
  localparam int NUM_HIDDEN_DEF        = 3;
  localparam int NUM_HIDDEN_LAYERS_DEF = 2;
  localparam int NUM_OUTPUTS_DEF       = 3;
  localparam int WEIGHT_DEPTH_DEF      = 64;

  // Field widths.
  localparam int DATA_W       = 16;
  localparam int IDX_W        = 6;
  localparam int NUM_FEATURES = 4;

  // Multiplier operand is one bit wider than the data so that the bias
  // scale of -256 can enter through the same multiplier.
  localparam int X_W = DATA_W + 1;
  localparam logic signed [X_W-1:0] BIAS_OPERAND = -17'sd256;

  // Accumulator: 33-bit products, up to seventeen terms, with margin.
  localparam int ACC_W = 40;

  // Activation: drop the Q8 fraction, divide by 1024, add one, scale by 128.
  localparam int FRAC_BITS = 8;
  localparam int DIV_BITS  = 10;
  localparam int OUT_SHIFT = 7;
  localparam int ACT_Q_W   = ACC_W - FRAC_BITS - DIV_BITS + 1;
  localparam logic signed [ACT_Q_W-1:0] ACT_P_MAX = 255;
  localparam logic signed [ACT_Q_W-1:0] ACT_P_MIN = -256;
  localparam logic signed [DATA_W-1:0]  SAT_MAX   = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0]  SAT_MIN   = -16'sh8000;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Input item.
  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         weight_index;
    logic signed [DATA_W-1:0] weight_value;
    logic signed [DATA_W-1:0] feature_zero;
    logic signed [DATA_W-1:0] feature_one;
    logic signed [DATA_W-1:0] feature_two;
    logic signed [DATA_W-1:0] feature_three;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]               neuron_index;
    logic signed [DATA_W-1:0] neuron_value;
    logic                     last;
  } out_item_t;

  // Sequencer controls for the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  // Activation of one accumulated sum, saturated to 16 bits signed.
  function automatic logic signed [DATA_W-1:0] activate(
    input logic signed [ACC_W-1:0] s
  );
    logic signed [ACT_Q_W-1:0] q;
    logic signed [ACT_Q_W-1:0] p;
    logic                      fix;
    logic signed [DATA_W-1:0]  res;
    // Floor shift, then correct towards zero when negative with a remainder.
    q   = ACT_Q_W'(s >>> (FRAC_BITS + DIV_BITS));
    fix = s[ACC_W-1] && (s[FRAC_BITS+DIV_BITS-1:FRAC_BITS] != '0);
    p   = q + ACT_Q_W'(1) + ACT_Q_W'(fix);
    if (p > ACT_P_MAX) begin
      res = SAT_MAX;
    end else if (p < ACT_P_MIN) begin
      res = SAT_MIN;
    end else begin
      res = {p[DATA_W-OUT_SHIFT-1:0], {OUT_SHIFT{1'b0}}};
    end
    return res;
  endfunction

endpackage

### src/fpmlp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpmlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/fpmlp_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Shared multiplier with a product register, an accumulator and the
// activation of the finished sum.
// ----------------------------------------------------------------------------
module fpmlp_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  fpmlp_pkg::mac_ctl_t                     ctl,
  input  logic signed [fpmlp_pkg::X_W-1:0]        x_op,
  input  logic signed [fpmlp_pkg::DATA_W-1:0]     w_rdata,
  output logic                                    busy,
  output logic signed [fpmlp_pkg::DATA_W-1:0]     act_value
);

  import fpmlp_pkg::*;

  logic                           s1_vld_r;
  logic                           s2_vld_r;
  logic signed [X_W-1:0]          s1_x_r;
  logic signed [DATA_W+X_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_nxt;

  // Pipeline valid bits follow the issued terms.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Operand is registered to line up with the registered weight read, then the product is registered.
  always_ff @(posedge clk) begin
    s1_x_r <= x_op;
    prod_r <= w_rdata * s1_x_r;
  end

  // Accumulator is cleared at the start of each neuron.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (s2_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign busy      = s1_vld_r | s2_vld_r;
  assign act_value = activate(acc_r);

endmodule

### src/fixed_point_mlp_forward_top.sv
// Operation: a load is written straight into the store; a run steps through each neuron in
// turn on the one shared multiply-accumulate unit: bias, one term per input, drain, activation.
// Runs do not overlap: in_ready is high only while idle. A run stalls while the output
// register holds a result waiting for out_ready; every weight comes through one store port.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// The weight store is not cleared and must be loaded before a run.
// ----------------------------------------------------------------------------
// Fixed-point perceptron forward pass
// Loads weight words into a store and runs the hidden and output layers
// term by term through one multiply-accumulate unit.
// ----------------------------------------------------------------------------
module fixed_point_mlp_forward_top #(
  parameter int NUM_INPUTS        = fpmlp_pkg::NUM_INPUTS_DEF,
  parameter int NUM_HIDDEN        = fpmlp_pkg::NUM_HIDDEN_DEF,
  parameter int NUM_HIDDEN_LAYERS = fpmlp_pkg::NUM_HIDDEN_LAYERS_DEF,
  parameter int NUM_OUTPUTS       = fpmlp_pkg::NUM_OUTPUTS_DEF,
  parameter int WEIGHT_DEPTH      = fpmlp_pkg::WEIGHT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpmlp_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpmlp_pkg::out_item_t  out_data
);

  import fpmlp_pkg::*;

  localparam int AW    = $clog2(WEIGHT_DEPTH);
  localparam int RW    = (AW + 1 > IDX_W + 1) ? AW + 1 : IDX_W + 1;
  localparam int MAXK  = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
  localparam int KW    = $clog2(MAXK + 1);
  localparam int MAXN  = (NUM_HIDDEN > NUM_OUTPUTS) ? NUM_HIDDEN : NUM_OUTPUTS;
  localparam int JW    = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int HJW   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int LW    = $clog2(NUM_HIDDEN_LAYERS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_ACT   = 2'd3;

  logic [1:0]               state_r;
  logic [KW-1:0]            k_r;
  logic [JW-1:0]            j_r;
  logic [LW-1:0]            layer_r;
  logic [AW-1:0]            addr_r;
  logic signed [DATA_W-1:0] feat_r [NUM_FEATURES];
  logic signed [DATA_W-1:0] cur_r  [NUM_HIDDEN];
  logic signed [DATA_W-1:0] prev_r [NUM_HIDDEN];
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     in_fire;
  logic                     load_we;
  logic [AW-1:0]            load_addr;
  logic [RW-1:0]            wrap_tmp;
  logic [DATA_W-1:0]        w_rdata;
  logic [KW-1:0]            kidx;
  logic [KW+1:0]            kpad;
  logic signed [X_W-1:0]    x_op;
  logic                     first_layer;
  logic                     out_layer;
  logic                     last_term;
  logic                     last_hidden;
  logic                     last_output;
  logic                     out_free;
  logic                     mac_busy;
  logic signed [DATA_W-1:0] act_value;
  mac_ctl_t                 mac_ctl;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_we  = in_fire && (in_data.command == CMD_LOAD);

  // Load address wraps modulo the store depth (at most three subtractions).
  always_comb begin
    wrap_tmp = RW'(in_data.weight_index);
    for (int i = 0; i < 3; i++) begin
      if (wrap_tmp >= RW'(WEIGHT_DEPTH)) begin
        wrap_tmp = wrap_tmp - RW'(WEIGHT_DEPTH);
      end
    end
    load_addr = wrap_tmp[AW-1:0];
  end

  // Weight store.
  fpmlp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WEIGHT_DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (in_data.weight_value),
    .raddr (addr_r),
    .rdata (w_rdata)
  );

  // Layer and term bookkeeping.
  assign first_layer = (layer_r == '0);
  assign out_layer   = (layer_r == LW'(NUM_HIDDEN_LAYERS));
  assign last_term   = first_layer ? (k_r == KW'(NUM_INPUTS)) : (k_r == KW'(NUM_HIDDEN));
  assign last_hidden = (j_r == JW'(NUM_HIDDEN - 1));
  assign last_output = (j_r == JW'(NUM_OUTPUTS - 1));
  assign out_free    = !out_valid_r || out_ready;

  // Operand selection: bias scale, a feature (zero past the fourth) or a previous-layer value.
  assign kidx = k_r - KW'(1);
  assign kpad = (KW + 2)'(kidx);

  always_comb begin
    if (k_r == '0) begin
      x_op = BIAS_OPERAND;
    end else if (first_layer) begin
      if (32'(kidx) < NUM_FEATURES) begin
        x_op = X_W'(feat_r[kpad[1:0]]);
      end else begin
        x_op = '0;
      end
    end else begin
      x_op = X_W'(prev_r[kidx[HJW-1:0]]);
    end
  end

  // Controls for the multiply-accumulate unit.
  always_comb begin
    mac_ctl.issue = (state_r == ST_MAC);
    mac_ctl.clear = (in_fire && (in_data.command == CMD_RUN)) ||
                    ((state_r == ST_ACT) && !(out_layer && (!out_free || last_output)));
  end

  fpmlp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .x_op      (x_op),
    .w_rdata   (w_rdata),
    .busy      (mac_busy),
    .act_value (act_value)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      layer_r <= '0;
      addr_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_data.command == CMD_RUN)) begin
            state_r <= ST_MAC;
            k_r     <= '0;
            j_r     <= '0;
            layer_r <= '0;
            addr_r  <= '0;
          end
        end
        ST_MAC: begin
          addr_r <= (addr_r == AW'(WEIGHT_DEPTH - 1)) ? '0 : addr_r + AW'(1);
          if (last_term) begin
            k_r     <= '0;
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state_r <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (!out_layer) begin
            state_r <= ST_MAC;
            if (last_hidden) begin
              j_r     <= '0;
              layer_r <= layer_r + LW'(1);
            end else begin
              j_r <= j_r + JW'(1);
            end
          end else if (out_free) begin
            if (last_output) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_MAC;
              j_r     <= j_r + JW'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Features are captured when a run is accepted.
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.command == CMD_RUN)) begin
      feat_r[0] <= in_data.feature_zero;
      feat_r[1] <= in_data.feature_one;
      feat_r[2] <= in_data.feature_two;
      feat_r[3] <= in_data.feature_three;
    end
  end

  // Hidden values: the current layer is built up, then handed to the next.
  always_ff @(posedge clk) begin
    if ((state_r == ST_ACT) && !out_layer) begin
      cur_r[j_r[HJW-1:0]] <= act_value;
      if (last_hidden) begin
        for (int i = 0; i < NUM_HIDDEN; i++) begin
          prev_r[i] <= (HJW'(i) == j_r[HJW-1:0]) ? act_value : cur_r[i];
        end
      end
    end
  end

  // Output register: holds one result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_ACT) && out_layer && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_ACT) && out_layer && out_free) begin
      out_r.neuron_index <= 2'(j_r);
      out_r.neuron_value <= act_value;
      out_r.last         <= last_output;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Perceptron forward-pass testbench
// Loads weight words and runs inferences through the forward-pass block.
// A directed table comes first, followed by random weight loads and runs.
// Every result transfer is checked against a local fixed-point predictor or a typed value.
// ----------------------------------------------------------------------------
module tb_top;
  import fpmlp_pkg::*;

  // Network shape as built by the block's default parameters.
  localparam int NIN        = NUM_INPUTS_DEF;
  localparam int NHID       = NUM_HIDDEN_DEF;
  localparam int NLAYERS    = NUM_HIDDEN_LAYERS_DEF;
  localparam int NOUT       = NUM_OUTPUTS_DEF;
  localparam int DEPTH      = WEIGHT_DEPTH_DEF;
  localparam int FIRST_WORDS = NHID * (NIN + 1);
  localparam int DEEP_WORDS  = NHID * (NHID + 1);
  localparam int OUT_BASE    = FIRST_WORDS + (NLAYERS - 1) * DEEP_WORDS;
  localparam int USED_WORDS  = OUT_BASE + NOUT * (NHID + 1);
  localparam int MAX_FAN     = (NIN > NHID) ? NIN : NHID;

  // Run length and timing limits.
  localparam int RANDOM_ITEMS  = 300;
  localparam int HOLD_ITEM     = 100;
  localparam int DRAIN_ITEM    = 200;
  localparam int QUIET_FIRST   = 220;
  localparam int QUIET_LAST    = 280;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 3000;

  typedef enum logic [1:0] {ROW_FILL, ROW_LOAD, ROW_RUN} row_kind_t;

  // One row of the directed table. A fill row writes its word to every used
  // store entry. A run row may carry a typed value expected on all outputs.
  typedef struct packed {
    row_kind_t                kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] word;
    logic signed [DATA_W-1:0] f0;
    logic signed [DATA_W-1:0] f1;
    logic signed [DATA_W-1:0] f2;
    logic signed [DATA_W-1:0] f3;
    logic                     typed;
    logic signed [DATA_W-1:0] typed_value;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Local copy of the weight store and the queue of expected results.
  logic signed [DATA_W-1:0] weight_mirror [DEPTH];
  out_item_t                pending_outputs [$];

  int  failures  = 0;
  int  n_loads   = 0;
  int  n_runs    = 0;
  int  n_results = 0;
  int  stall_count;
  bit  quiet     = 1'b0;
  bit  hold_req  = 1'b0;
  bit  hold_done = 1'b0;

  fixed_point_mlp_forward_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fires one neuron: bias scaled by -256, plus weight times input, then
  // floor shift by 8, truncating divide by 1024, add one, scale by 128 and saturate.
  function automatic logic signed [DATA_W-1:0] neuron_fire(
    input int     base,
    input longint x [MAX_FAN],
    input int     fan_in
  );
    longint acc;
    longint v;
    acc = -longint'(weight_mirror[base % DEPTH]) * 256;
    for (int k = 0; k < fan_in; k++) begin
      acc += longint'(weight_mirror[(base + 1 + k) % DEPTH]) * x[k];
    end
    v = ((acc >>> 8) / 1024 + 1) * 128;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return DATA_W'(v);
  endfunction

  // Applies an accepted item to the local state and queues the results of a
  // run: predicted, or the typed value where the table gives one.
  task automatic forward_pass(
    input in_item_t                 item,
    input logic                     typed,
    input logic signed [DATA_W-1:0] typed_value
  );
    longint                   acts [MAX_FAN];
    logic signed [DATA_W-1:0] layer [NHID];
    out_item_t                res;
    if (item.command == CMD_LOAD) begin
      weight_mirror[item.weight_index] = item.weight_value;
      n_loads++;
    end else begin
      n_runs++;
      foreach (acts[k]) acts[k] = 0;
      acts[0] = item.feature_zero;
      acts[1] = item.feature_one;
      acts[2] = item.feature_two;
      acts[3] = item.feature_three;
      for (int j = 0; j < NHID; j++) begin
        layer[j] = neuron_fire(j * (NIN + 1), acts, NIN);
      end
      // Deeper hidden layers read the layer before them.
      for (int h = 1; h < NLAYERS; h++) begin
        for (int k = 0; k < NHID; k++) acts[k] = layer[k];
        for (int j = 0; j < NHID; j++) begin
          layer[j] = neuron_fire(FIRST_WORDS + (h - 1) * DEEP_WORDS + j * (NHID + 1),
                                 acts, NHID);
        end
      end
      for (int k = 0; k < NHID; k++) acts[k] = layer[k];
      for (int j = 0; j < NOUT; j++) begin
        res.neuron_index = 2'(j);
        res.neuron_value = typed ? typed_value
                                 : neuron_fire(OUT_BASE + j * (NHID + 1), acts, NHID);
        res.last         = (j == NOUT - 1);
        pending_outputs.push_back(res);
      end
    end
  endtask

  // Offers one item and waits for its transfer, idling now and then first.
  task automatic offer(input in_item_t item);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // A random 16-bit word: mostly modest magnitudes so that outputs do not
  // always saturate, with a share of full-range values.
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return DATA_W'($urandom);
      3:       return DATA_W'(int'($urandom_range(0, 510)) - 255);
      default: return DATA_W'(int'($urandom_range(0, 4094)) - 2047);
    endcase
  endfunction

  function automatic stim_row_t mk_row(
    input row_kind_t kind,
    input int        index,
    input int        word,
    input int        f0,
    input int        f1,
    input int        f2,
    input int        f3,
    input logic      typed,
    input int        typed_value
  );
    stim_row_t r;
    r.kind        = kind;
    r.index       = IDX_W'(index);
    r.word        = DATA_W'(word);
    r.f0          = DATA_W'(f0);
    r.f1          = DATA_W'(f1);
    r.f2          = DATA_W'(f2);
    r.f3          = DATA_W'(f3);
    r.typed       = typed;
    r.typed_value = DATA_W'(typed_value);
    return r;
  endfunction

  // Stimulus: reset, directed table, random part, then the final verdict.
  initial begin : stimulus
    stim_row_t stim_table [$];
    stim_row_t row;
    in_item_t  item;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // All-zero weights give 128 everywhere; full-scale weights saturate.
    // Output biases of 1025 and 1024 show the truncating divide.
    stim_table.push_back(mk_row(ROW_FILL, 0, 0, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 0, 0, 0, 0, 1'b1, 128));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 32767, -32768, 32767, -32768, 1'b1, 128));
    stim_table.push_back(mk_row(ROW_LOAD, OUT_BASE, 1025, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, OUT_BASE + NHID + 1, 1024, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, OUT_BASE + 2 * (NHID + 1), -1023, 0, 0, 0, 0,
                                1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, DEPTH - 1, 32767, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, 0, -32768, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, 1, -1, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 256, -256, 1, -1, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_FILL, 0, 32767, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 32767, 32767, 32767, 32767, 1'b1, 32767));
    stim_table.push_back(mk_row(ROW_FILL, 0, -32768, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 32767, 32767, 32767, 32767, 1'b1, -32768));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, -32768, -32768, -32768, -32768, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_FILL, 0, 3, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_LOAD, FIRST_WORDS + 1, -700, 0, 0, 0, 0, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, 1000, -3000, 20000, -12345, 1'b0, 0));
    stim_table.push_back(mk_row(ROW_RUN, 0, 0, -1, 1, -1, 1, 1'b0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every used store entry is written before the first run.
    foreach (stim_table[r]) begin
      row                = stim_table[r];
      item.command       = (row.kind == ROW_RUN) ? CMD_RUN : CMD_LOAD;
      item.weight_index  = row.index;
      item.weight_value  = row.word;
      item.feature_zero  = row.f0;
      item.feature_one   = row.f1;
      item.feature_two   = row.f2;
      item.feature_three = row.f3;
      if (row.kind == ROW_FILL) begin
        for (int a = 0; a < USED_WORDS; a++) begin
          item.weight_index = IDX_W'(a);
          offer(item);
          forward_pass(item, 1'b0, '0);
        end
      end else begin
        offer(item);
        forward_pass(item, row.typed, row.typed_value);
      end
    end

    // Random part: weight updates anywhere in the store mixed with runs.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_ITEM) hold_req = 1'b1;
      if (i == DRAIN_ITEM) begin
        // Pause until every outstanding result has been transferred.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
      end
      quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
      item.command       = ($urandom_range(0, 99) < 35) ? CMD_RUN : CMD_LOAD;
      item.weight_index  = IDX_W'($urandom_range(0, DEPTH - 1));
      item.weight_value  = rand_word();
      item.feature_zero  = rand_word();
      item.feature_one   = rand_word();
      item.feature_two   = rand_word();
      item.feature_three = rand_word();
      offer(item);
      forward_pass(item, 1'b0, '0);
    end
    quiet = 1'b0;

    // Wait for the remaining results, then watch for anything spurious.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d weight loads and %0d inferences, %0d output transfers checked.",
             n_loads, n_runs, n_results);
    $display("Receiver hold-off done: %0d, mismatches: %0d.", hold_done, failures);
    if (failures == 0) begin
      $display("PASS fixed_point_mlp_forward_top");
    end else begin
      $display("FAIL fixed_point_mlp_forward_top");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off while the sender
  // keeps offering items.
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= rst_n && (quiet || $urandom_range(0, 99) >= 10);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result: index %0d value %0d last %0d",
                 $time, out_data.neuron_index, out_data.neuron_value, out_data.last);
        failures++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_data.neuron_index !== want.neuron_index) begin
          $display("%0t: neuron_index mismatch: expected %0d, actual %0d",
                   $time, want.neuron_index, out_data.neuron_index);
          failures++;
        end
        if (out_data.neuron_value !== want.neuron_value) begin
          $display("%0t: neuron_value mismatch on neuron %0d: expected %0d, actual %0d",
                   $time, want.neuron_index, want.neuron_value, out_data.neuron_value);
          failures++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch on neuron %0d: expected %0d, actual %0d",
                   $time, want.neuron_index, want.last, out_data.last);
          failures++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (rst_n && stall_count >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, stall_count, pending_outputs.size());
      $display("FAIL fixed_point_mlp_forward_top");
      $finish;
    end
  end

endmodule
